[rtl/core/ihex_pkg.sv]
package ihex_pkg;

  localparam int AddrW = 17;
  localparam int ByteW = 8;
  localparam int FieldW = 16;

  localparam logic [ByteW-1:0] ColonChar = 8'h3a;

  localparam logic [AddrW-1:0] InitLowReset = 17'd1;
  localparam logic [AddrW-1:0] InitHighReset = 17'd0;

  typedef enum logic [2:0] {
    PH_SEEK = 3'd0,
    PH_LEN  = 3'd1,
    PH_ADDR = 3'd2,
    PH_TYPE = 3'd3,
    PH_DATA = 3'd4,
    PH_CSUM = 3'd5
  } phase_t;

  typedef enum logic {
    REG_INIT_LOW  = 1'b0,
    REG_INIT_HIGH = 1'b1
  } reg_idx_t;

  typedef enum logic {
    RES_WRITE = 1'b0,
    RES_DONE  = 1'b1
  } res_kind_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } nib_t;

  function automatic nib_t hex_nibble(input logic [ByteW-1:0] c);
    nib_t r;
    r.ok = 1'b1;
    r.val = 4'd0;
    if (c inside {[8'h30:8'h39]}) begin
      r.val = 4'(c - 8'h30);
    end else if (c inside {[8'h41:8'h46]}) begin
      r.val = 4'(c - 8'h37);
    end else if (c inside {[8'h61:8'h66]}) begin
      r.val = 4'(c - 8'h57);
    end else begin
      r.ok = 1'b0;
    end
    return r;
  endfunction

endpackage

[rtl/core/intel_hex_record_parser.sv]
// A character word is held in the input register and its result word (if any) is
// registered in the result register; a stalled result holds the character back.
// Throughput: one character per cycle while the result register is not stalled;
// the field decode, byte-sum add and bound compares all sit between the two registers.
// Reset (rst, synchronous): config back to initial_low=1, initial_high=0,
// parser seeks a colon, both pipeline registers empty.
module intel_hex_record_parser (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          kind,
  input  logic [ihex_pkg::ByteW-1:0]    input_char,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          result_kind,
  output logic [ihex_pkg::AddrW-1:0]    address,
  output logic [ihex_pkg::ByteW-1:0]    data_byte,
  output logic                          checksum_ok,
  output logic [ihex_pkg::AddrW-1:0]    low_address,
  output logic [ihex_pkg::AddrW-1:0]    high_address,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [2:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import ihex_pkg::*;

  // configuration
  logic [AddrW-1:0] initial_low;
  logic [AddrW-1:0] initial_high;
  logic             cfg_wr;
  reg_idx_t         cfg_idx;

  assign pready = 1'b1;
  assign cfg_idx = reg_idx_t'(paddr[2]);
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      initial_low <= InitLowReset;
      initial_high <= InitHighReset;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_INIT_LOW:  initial_low <= pwdata[AddrW-1:0];
        REG_INIT_HIGH: initial_high <= pwdata[AddrW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_INIT_LOW:  prdata = {{(32-AddrW){1'b0}}, initial_low};
      REG_INIT_HIGH: prdata = {{(32-AddrW){1'b0}}, initial_high};
      default:       prdata = '0;
    endcase
  end

  // input register
  logic             in_q_valid;
  logic             kind_q;
  logic [ByteW-1:0] char_q;
  logic             out_free;
  logic             proc_fire;

  assign out_free = !out_valid || !out_stall;
  assign proc_fire = in_q_valid && out_free;
  assign in_stall = in_q_valid && !out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      in_q_valid <= 1'b1;
    end else if (proc_fire) begin
      in_q_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      kind_q <= kind;
      char_q <= input_char;
    end
  end

  // parser state
  phase_t            phase, phase_next;
  logic [1:0]        digit_count, digit_count_next;
  logic [FieldW-1:0] field_value, field_value_next;
  logic              field_stopped, field_stopped_next;
  logic [ByteW-1:0]  bytes_left, bytes_left_next;
  logic [FieldW-1:0] base_address, base_address_next;
  logic [AddrW-1:0]  next_address, next_address_next;
  logic [ByteW-1:0]  byte_sum, byte_sum_next;
  logic [AddrW-1:0]  lowest_start, lowest_start_next;
  logic [AddrW-1:0]  highest_end, highest_end_next;

  nib_t              nib;
  logic [FieldW-1:0] fv;
  logic              field_done;
  logic [ByteW-1:0]  sum_add;

  assign nib = hex_nibble(char_q);
  // once a non-hex char is seen the rest of the field is ignored
  assign fv = (!field_stopped && nib.ok) ? {field_value[FieldW-5:0], nib.val} : field_value;
  assign field_done = (phase == PH_ADDR) ? (digit_count == 2'd3) : (digit_count != 2'd0);
  assign sum_add = byte_sum + fv[ByteW-1:0];

  always_comb begin
    phase_next = phase;
    if (proc_fire) begin
      if (kind_q) begin
        phase_next = PH_SEEK;
      end else begin
        case (phase)
          PH_SEEK: if (char_q == ColonChar) phase_next = PH_LEN;
          PH_LEN:  if (field_done) phase_next = PH_ADDR;
          PH_ADDR: if (field_done) phase_next = PH_TYPE;
          PH_TYPE: begin
            if (field_done) begin
              if (fv != '0) phase_next = PH_SEEK;
              else if (bytes_left != '0) phase_next = PH_DATA;
              else phase_next = PH_CSUM;
            end
          end
          PH_DATA: if (field_done && bytes_left == 8'd1) phase_next = PH_CSUM;
          PH_CSUM: if (field_done) phase_next = PH_SEEK;
          default: phase_next = PH_SEEK;
        endcase
      end
    end
  end

  logic             emit;
  res_kind_t        res_kind_next;
  logic [AddrW-1:0] res_addr_next;
  logic [ByteW-1:0] res_data_next;
  logic             res_ok_next;

  always_comb begin
    digit_count_next = digit_count;
    field_value_next = field_value;
    field_stopped_next = field_stopped;
    bytes_left_next = bytes_left;
    base_address_next = base_address;
    next_address_next = next_address;
    byte_sum_next = byte_sum;
    lowest_start_next = lowest_start;
    highest_end_next = highest_end;
    emit = 1'b0;
    res_kind_next = RES_WRITE;
    res_addr_next = next_address;
    res_data_next = fv[ByteW-1:0];
    res_ok_next = 1'b0;
    if (proc_fire) begin
      if (kind_q) begin
        digit_count_next = '0;
        field_value_next = '0;
        field_stopped_next = 1'b0;
        bytes_left_next = '0;
        base_address_next = '0;
        next_address_next = '0;
        byte_sum_next = '0;
        lowest_start_next = initial_low;
        highest_end_next = initial_high;
      end else if (phase == PH_SEEK) begin
        if (char_q == ColonChar) begin
          digit_count_next = '0;
          field_value_next = '0;
          field_stopped_next = 1'b0;
          byte_sum_next = '0;
        end
      end else if (phase == PH_LEN || phase == PH_ADDR || phase == PH_TYPE ||
                   phase == PH_DATA || phase == PH_CSUM) begin
        field_value_next = fv;
        field_stopped_next = field_stopped || !nib.ok;
        digit_count_next = digit_count + 2'd1;
        if (field_done) begin
          digit_count_next = '0;
          field_value_next = '0;
          field_stopped_next = 1'b0;
          case (phase)
            PH_LEN: begin
              bytes_left_next = fv[ByteW-1:0];
              byte_sum_next = sum_add;
            end
            PH_ADDR: begin
              base_address_next = fv;
              next_address_next = {1'b0, fv};
              byte_sum_next = sum_add + fv[FieldW-1:ByteW];
            end
            PH_TYPE: byte_sum_next = sum_add;
            PH_DATA: begin
              emit = 1'b1;
              next_address_next = next_address + 17'd1;
              byte_sum_next = sum_add;
              bytes_left_next = bytes_left - 8'd1;
            end
            default: begin
              // checksum field: close the record
              byte_sum_next = sum_add;
              if (lowest_start > {1'b0, base_address}) lowest_start_next = {1'b0, base_address};
              if (highest_end < next_address) highest_end_next = next_address;
              emit = 1'b1;
              res_kind_next = RES_DONE;
              res_addr_next = {1'b0, base_address};
              res_data_next = '0;
              res_ok_next = (sum_add == '0);
            end
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_SEEK;
      digit_count <= '0;
      field_value <= '0;
      field_stopped <= 1'b0;
      bytes_left <= '0;
      base_address <= '0;
      next_address <= '0;
      byte_sum <= '0;
      lowest_start <= InitLowReset;
      highest_end <= InitHighReset;
    end else begin
      phase <= phase_next;
      digit_count <= digit_count_next;
      field_value <= field_value_next;
      field_stopped <= field_stopped_next;
      bytes_left <= bytes_left_next;
      base_address <= base_address_next;
      next_address <= next_address_next;
      byte_sum <= byte_sum_next;
      lowest_start <= lowest_start_next;
      highest_end <= highest_end_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (proc_fire && emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc_fire && emit) begin
      result_kind <= res_kind_next;
      address <= res_addr_next;
      data_byte <= res_data_next;
      checksum_ok <= res_ok_next;
      low_address <= lowest_start_next;
      high_address <= highest_end_next;
    end
  end

`ifndef ASSERT_OFF
  a_write_no_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && (result_kind == RES_WRITE) |-> !checksum_ok)
    else $error("data write word carries checksum flag");

  a_done_zero_data: assert property (@(posedge clk) disable iff (rst)
    out_valid && (result_kind == RES_DONE) |-> (data_byte == '0))
    else $error("record-done word carries nonzero data");

  a_restart_seek: assert property (@(posedge clk) disable iff (rst)
    proc_fire && kind_q |=> (phase == PH_SEEK) && (byte_sum == '0) && !out_valid ||
      (phase == PH_SEEK) && (byte_sum == '0) && $past(out_valid && out_stall))
    else $error("restart did not return parser to colon search");

  a_stall_when_blocked: assert property (@(posedge clk) disable iff (rst)
    in_q_valid && !proc_fire |-> in_stall)
    else $error("input accepted while held character is blocked");
`endif

endmodule

[tb/tb_intel_hex_record_parser.sv]
`timescale 1ns / 1ps

module tb_intel_hex_record_parser;
  import ihex_pkg::*;

  localparam int IdleLimit = 4000;
  localparam int ItemsPerPhase = 250;

  typedef struct packed {
    res_kind_t        kind;
    logic [AddrW-1:0] addr;
    logic [ByteW-1:0] data;
    logic             ok;
    logic [AddrW-1:0] lo;
    logic [AddrW-1:0] hi;
  } hex_result_t;

  typedef struct packed {
    logic             k;
    logic [ByteW-1:0] ch;
    bit               typed;
    hex_result_t      res;
  } stim_row_t;

  localparam hex_result_t NoRes = '0;

  // directed records: leading junk, zero-length record at the top address,
  // restart, one data byte at FFFF (end grows past 16 bits), then a record
  // with a colon inside its length field and a nonzero type
  localparam stim_row_t DirectedRows [35] = '{
    '{1'b0, "x", 1'b0, NoRes},
    '{1'b0, ":", 1'b0, NoRes}, '{1'b0, "0", 1'b0, NoRes}, '{1'b0, "0", 1'b0, NoRes},
    '{1'b0, "F", 1'b0, NoRes}, '{1'b0, "F", 1'b0, NoRes}, '{1'b0, "F", 1'b0, NoRes},
    '{1'b0, "F", 1'b0, NoRes}, '{1'b0, "0", 1'b0, NoRes}, '{1'b0, "0", 1'b0, NoRes},
    '{1'b0, "0", 1'b0, NoRes},
    '{1'b0, "2", 1'b1, '{RES_DONE, 17'h0FFFF, 8'h00, 1'b1, 17'd1, 17'h0FFFF}},
    '{1'b1, 8'hA5, 1'b0, NoRes},
    '{1'b0, ":", 1'b0, NoRes}, '{1'b0, "0", 1'b0, NoRes}, '{1'b0, "1", 1'b0, NoRes},
    '{1'b0, "F", 1'b0, NoRes}, '{1'b0, "F", 1'b0, NoRes}, '{1'b0, "F", 1'b0, NoRes},
    '{1'b0, "F", 1'b0, NoRes}, '{1'b0, "0", 1'b0, NoRes}, '{1'b0, "0", 1'b0, NoRes},
    '{1'b0, "f", 1'b0, NoRes},
    '{1'b0, "f", 1'b1, '{RES_WRITE, 17'h0FFFF, 8'hFF, 1'b0, 17'd1, 17'd0}},
    '{1'b0, "0", 1'b0, NoRes},
    '{1'b0, "2", 1'b1, '{RES_DONE, 17'h0FFFF, 8'h00, 1'b1, 17'd1, 17'h10000}},
    '{1'b0, ":", 1'b0, NoRes}, '{1'b0, "0", 1'b0, NoRes}, '{1'b0, ":", 1'b0, NoRes},
    '{1'b0, "F", 1'b0, NoRes}, '{1'b0, "F", 1'b0, NoRes}, '{1'b0, "F", 1'b0, NoRes},
    '{1'b0, "F", 1'b0, NoRes}, '{1'b0, "0", 1'b0, NoRes}, '{1'b0, "1", 1'b0, NoRes}
  };

  logic             clk;
  logic             rst = 1'b1;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic             kind = 1'b0;
  logic [ByteW-1:0] input_char = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic             result_kind;
  logic [AddrW-1:0] address;
  logic [ByteW-1:0] data_byte;
  logic             checksum_ok;
  logic [AddrW-1:0] low_address;
  logic [AddrW-1:0] high_address;
  logic             psel = 1'b0;
  logic             penable = 1'b0;
  logic             pwrite = 1'b0;
  logic [2:0]       paddr = '0;
  logic [31:0]      pwdata = '0;
  logic [31:0]      prdata;
  logic             pready;

  intel_hex_record_parser uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .kind(kind), .input_char(input_char),
    .out_valid(out_valid), .out_stall(out_stall), .result_kind(result_kind),
    .address(address), .data_byte(data_byte), .checksum_ok(checksum_ok),
    .low_address(low_address), .high_address(high_address),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // parser shadow state
  phase_t           ph;
  int               ndig;
  logic [15:0]      fval;
  bit               stopped;
  logic [7:0]       left;
  logic [7:0]       sum;
  logic [15:0]      base;
  logic [AddrW-1:0] waddr;
  logic [AddrW-1:0] lo_bound;
  logic [AddrW-1:0] hi_bound;
  logic [AddrW-1:0] cfg_low = InitLowReset;
  logic [AddrW-1:0] cfg_high = InitHighReset;

  hex_result_t due_results[$];
  logic [7:0]  line_q[$];

  int  mismatches = 0;
  int  words_checked = 0;
  int  records_sent = 0;
  int  restarts_sent = 0;
  int  settings_used = 1;
  int  idle_cycles = 0;
  bit  calm_in = 1'b0;
  bit  calm_out = 1'b0;
  int  stall_run = 0;

  task automatic log_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 40) $display("MISMATCH @%0t: %s", $time, msg);
  endtask

  function automatic void reload_bounds();
    ph = PH_SEEK;
    ndig = 0;
    fval = '0;
    stopped = 1'b0;
    left = '0;
    sum = '0;
    base = '0;
    waddr = '0;
    lo_bound = cfg_low;
    hi_bound = cfg_high;
  endfunction

  function automatic bit hex_value(input logic [7:0] c, output logic [3:0] n);
    n = '0;
    if (c >= "0" && c <= "9") n = 4'(c - "0");
    else if (c >= "A" && c <= "F") n = 4'(c - "A" + 8'd10);
    else if (c >= "a" && c <= "f") n = 4'(c - "a" + 8'd10);
    else return 1'b0;
    return 1'b1;
  endfunction

  // advance the shadow parser by one word; returns 1 when a result is due
  function automatic bit decode_char(input logic k, input logic [7:0] c,
                                     output hex_result_t r);
    logic [3:0]  n;
    bit          is_hex;
    int          need;
    logic [15:0] v;
    r = '0;
    if (k) begin
      reload_bounds();
      return 1'b0;
    end
    if (ph == PH_SEEK) begin
      if (c == ColonChar) begin
        ph = PH_LEN;
        ndig = 0;
        fval = '0;
        stopped = 1'b0;
        sum = '0;
      end
      return 1'b0;
    end
    is_hex = hex_value(c, n);
    if (!stopped && is_hex) fval = {fval[11:0], n};
    else stopped = 1'b1;
    need = (ph == PH_ADDR) ? 4 : 2;
    if (ndig + 1 < need) begin
      ndig++;
      return 1'b0;
    end
    v = fval;
    ndig = 0;
    fval = '0;
    stopped = 1'b0;
    case (ph)
      PH_LEN: begin
        left = v[7:0];
        sum = sum + v[7:0];
        ph = PH_ADDR;
      end
      PH_ADDR: begin
        base = v;
        waddr = {1'b0, v};
        sum = sum + v[15:8] + v[7:0];
        ph = PH_TYPE;
      end
      PH_TYPE: begin
        sum = sum + v[7:0];
        if (v != 0) ph = PH_SEEK;
        else if (left != 0) ph = PH_DATA;
        else ph = PH_CSUM;
      end
      PH_DATA: begin
        r = '{RES_WRITE, waddr, v[7:0], 1'b0, lo_bound, hi_bound};
        waddr = waddr + 1'b1;
        sum = sum + v[7:0];
        left = left - 1'b1;
        if (left == 0) ph = PH_CSUM;
        return 1'b1;
      end
      default: begin
        sum = sum + v[7:0];
        if (lo_bound > {1'b0, base}) lo_bound = {1'b0, base};
        if (hi_bound < waddr) hi_bound = waddr;
        r = '{RES_DONE, {1'b0, base}, 8'h00, (sum == 8'h00), lo_bound, hi_bound};
        ph = PH_SEEK;
        return 1'b1;
      end
    endcase
    return 1'b0;
  endfunction

  function automatic int pick_gap(input bit calm);
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // one input word; prediction is made at the edge that accepts it
  task automatic push_word(input logic k, input logic [7:0] c, input bit typed,
                           input hex_result_t want);
    hex_result_t got;
    bit          makes;
    int          gap;
    gap = pick_gap(calm_in);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    kind <= k;
    input_char <= c;
    do @(posedge clk); while (in_stall !== 1'b0);
    makes = decode_char(k, c, got);
    if (typed) due_results.push_back(want);
    else if (makes) due_results.push_back(got);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic reg_write(input reg_idx_t idx, input logic [AddrW-1:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {15'd0, val};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == REG_INIT_LOW) cfg_low = val;
    else cfg_high = val;
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    if (n < 4'd10) return "0" + 8'(n);
    return ($urandom_range(0, 1) ? "A" : "a") + 8'(n) - 8'd10;
  endfunction

  function automatic void put_byte(input logic [7:0] b);
    line_q.push_back(hex_char(b[7:4]));
    line_q.push_back(hex_char(b[3:0]));
  endfunction

  // one record with random content, sometimes damaged; returns counted words
  task automatic send_record(output int counted);
    logic [7:0]  len, typ, ck, b, rsum;
    logic [15:0] at;
    int          start;
    int          cut;
    line_q.delete();
    calm_in = ($urandom_range(0, 5) == 0);
    calm_out = ($urandom_range(0, 5) == 0);
    repeat ($urandom_range(0, 3)) begin
      b = 8'($urandom_range(0, 255));
      line_q.push_back(b == ColonChar ? "x" : b);
    end
    start = line_q.size();
    typ = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(1, 255)) : 8'h00;
    if (typ != 0) len = 8'($urandom_range(0, 255));
    else if ($urandom_range(0, 39) == 0) len = 8'($urandom_range(64, 255));
    else len = 8'($urandom_range(0, 12));
    case ($urandom_range(0, 7))
      0, 1: at = {8'hFF, 8'($urandom_range(0, 255))};
      2: at = 16'($urandom_range(0, 15));
      default: at = 16'($urandom_range(0, 65535));
    endcase
    line_q.push_back(ColonChar);
    put_byte(len);
    put_byte(at[15:8]);
    put_byte(at[7:0]);
    put_byte(typ);
    rsum = len + at[15:8] + at[7:0] + typ;
    if (typ == 0) begin
      repeat (len) begin
        b = 8'($urandom_range(0, 255));
        put_byte(b);
        rsum = rsum + b;
      end
    end
    ck = 8'h00 - rsum;
    if ($urandom_range(0, 6) == 0) ck = 8'($urandom_range(0, 255));
    put_byte(ck);
    if ($urandom_range(0, 9) == 0)
      line_q[$urandom_range(start + 1, line_q.size() - 1)] = 8'($urandom_range(0, 255));
    if ($urandom_range(0, 14) == 0) begin
      cut = $urandom_range(start + 1, line_q.size() - 1);
      while (line_q.size() > cut) void'(line_q.pop_back());
    end
    if ($urandom_range(0, 1) == 0) begin
      line_q.push_back(8'h0D);
      line_q.push_back(8'h0A);
    end
    counted = line_q.size() - start;
    records_sent++;
    foreach (line_q[i]) begin
      if ($urandom_range(0, 299) == 0) begin
        push_word(1'b1, 8'($urandom_range(0, 255)), 1'b0, NoRes);
        restarts_sent++;
      end
      push_word(1'b0, line_q[i], 1'b0, NoRes);
    end
  endtask

  // receiver: random stall runs, mostly short
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      stall_run = 0;
    end else if (stall_run > 0) begin
      stall_run--;
      out_stall <= 1'b1;
    end else if (!calm_out && $urandom_range(0, 3) == 0) begin
      stall_run = ($urandom_range(0, 4) == 0) ? $urandom_range(5, 47) : $urandom_range(0, 2);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin : check_results
    hex_result_t want;
    if (!rst && out_valid === 1'b1 && out_stall === 1'b0) begin
      words_checked++;
      if (due_results.size() == 0) begin
        log_mismatch("result word with nothing expected");
      end else begin
        want = due_results.pop_front();
        if (result_kind !== want.kind)
          log_mismatch($sformatf("result_kind %0d, want %0d", result_kind, want.kind));
        if (address !== want.addr)
          log_mismatch($sformatf("address %h, want %h", address, want.addr));
        if (data_byte !== want.data)
          log_mismatch($sformatf("data_byte %h, want %h", data_byte, want.data));
        if (checksum_ok !== want.ok)
          log_mismatch($sformatf("checksum_ok %0d, want %0d", checksum_ok, want.ok));
        if (low_address !== want.lo)
          log_mismatch($sformatf("low_address %h, want %h", low_address, want.lo));
        if (high_address !== want.hi)
          log_mismatch($sformatf("high_address %h, want %h", high_address, want.hi));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IdleLimit) begin
      $display("Watchdog: no word moved for %0d cycles", IdleLimit);
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    int counted;
    int sent;
    logic [AddrW-1:0] new_low, new_high;
    reload_bounds();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (DirectedRows[i])
      push_word(DirectedRows[i].k, DirectedRows[i].ch, DirectedRows[i].typed,
                DirectedRows[i].res);

    for (int p = 0; p < 5; p++) begin
      if (p > 0) begin
        settle();
        case (p)
          1: begin new_low = 17'd65790; new_high = 17'd0; end
          2: begin new_low = 17'd0; new_high = 17'd65790; end
          3: begin new_low = 17'd0; new_high = 17'd0; end
          default: begin
            new_low = 17'($urandom_range(0, 65790));
            new_high = 17'($urandom_range(0, 65790));
          end
        endcase
        reg_write(REG_INIT_LOW, new_low);
        reg_write(REG_INIT_HIGH, new_high);
        settings_used++;
        // new bounds only load on a restart word
        push_word(1'b1, 8'($urandom_range(0, 255)), 1'b0, NoRes);
        restarts_sent++;
      end
      sent = 0;
      while (sent < ItemsPerPhase) begin
        send_record(counted);
        sent += counted;
      end
    end

    settle();
    $display("Sent %0d records and %0d restarts over %0d bound settings;",
             records_sent, restarts_sent, settings_used);
    $display("checked %0d result words against the shadow parser.", words_checked);
    if (mismatches == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule
